@@ design/mmc3_pkg.sv @@
// ----------------------------------------------------------------------------
// mmc3_pkg
// Shared types and constants of the MMC3 bank mapper: beat payloads, command
// and target codes, register indexes and CPU and PPU address map boundaries.
// ----------------------------------------------------------------------------
package mmc3_pkg;

    // Bus access commands.
    localparam logic [1:0] CMD_CPU_READ  = 2'd0;
    localparam logic [1:0] CMD_CPU_WRITE = 2'd1;
    localparam logic [1:0] CMD_PPU_READ  = 2'd2;
    localparam logic [1:0] CMD_PPU_WRITE = 2'd3;

    // Target memories.
    localparam logic [1:0] TARGET_NONE    = 2'd0;
    localparam logic [1:0] TARGET_PRG_RAM = 2'd1;
    localparam logic [1:0] TARGET_PRG_ROM = 2'd2;
    localparam logic [1:0] TARGET_CHR     = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] REG_PRG_BANK_COUNT  = 2'd0;
    localparam logic [1:0] REG_PRG_RAM_PRESENT = 2'd1;
    localparam logic [1:0] REG_CHR_IS_ROM      = 2'd2;

    // Configuration reset values.
    localparam logic [6:0] PRG_BANK_COUNT_RESET = 7'd32;

    // CPU and PPU address map boundaries.
    localparam logic [15:0] ADDR_UNMAPPED  = 16'h4020;
    localparam logic [15:0] ADDR_PRG_RAM   = 16'h6000;
    localparam logic [15:0] ADDR_PRG_ROM   = 16'h8000;
    localparam logic [15:0] ADDR_MIRROR    = 16'hA000;
    localparam logic [15:0] ADDR_PATTERN_END = 16'h2000;

    // Bank register write masks.
    localparam logic [7:0] CHR_2K_MASK = 8'b1111_1110;
    localparam logic [7:0] PRG_MASK    = 8'b0011_1111;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [15:0] bus_address;
        logic [7:0]  write_data;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  target;
        logic [18:0] mapped_address;
        logic        write_enable;
        logic        dropped;
        logic        mirror_horizontal;
    } out_item_t;

    typedef struct packed {
        logic [6:0] prg_bank_count;
        logic       prg_ram_present;
        logic       chr_is_rom;
    } cfg_t;

    // Mapper register updates produced by one access.
    typedef struct packed {
        logic       sel_we;
        logic       bank_we;
        logic [2:0] bank_idx;
        logic       mirror_we;
        logic [7:0] data;
    } map_update_t;

endpackage

@@ design/mmc3_xlate.sv @@
// ----------------------------------------------------------------------------
// mmc3_xlate
// Decodes one bus access against the current mapper registers: target memory,
// translated address, write enable and drop flags, plus register updates.
// ----------------------------------------------------------------------------
module mmc3_xlate #(
    parameter int unsigned CHR_RAM_BANKS_1K = 8
) (
    input  mmc3_pkg::in_item_t    item,
    input  mmc3_pkg::cfg_t        cfg,
    input  logic [7:0]            sel_byte,
    input  logic [7:0][7:0]       banks,
    input  logic                  mirroring,
    output mmc3_pkg::out_item_t   result,
    output mmc3_pkg::map_update_t update
);

    logic        is_write;
    logic        is_ppu;
    logic [15:0] a;
    logic [12:0] chr_a;
    logic [2:0]  rd_idx;
    logic [7:0]  bank_val;
    logic [17:0] chr_addr;
    logic [5:0]  second_last;
    logic [5:0]  last;
    logic [5:0]  prg_bank;
    logic        swap;
    logic        chr_out_of_range;
    logic [2:0]  wr_idx;

    assign a        = item.bus_address;
    assign is_write = item.cmd[0];
    assign is_ppu   = item.cmd[1];
    assign swap     = sel_byte[6];
    assign chr_a    = a[12:0] ^ {sel_byte[7], 12'd0};

    assign second_last = cfg.prg_bank_count[5:0] - 6'd2;
    assign last        = cfg.prg_bank_count[5:0] - 6'd1;

    // One bank register is read per access: a CHR window or the R6/R7 slot.
    always_comb
    begin
        if (is_ppu)
        begin
            if (!chr_a[12])
                rd_idx = {2'b00, chr_a[11]};
            else
                rd_idx = 3'd2 + {1'b0, chr_a[11:10]};
        end
        else
        begin
            rd_idx = (a[14:13] == 2'b01) ? 3'd7 : 3'd6;
        end
    end

    assign bank_val = banks[rd_idx];

    assign chr_addr = chr_a[12] ? {bank_val, chr_a[9:0]}
                                : {bank_val[7:1], chr_a[10:0]};

    assign chr_out_of_range = {1'b0, chr_addr[17:10]} >= 9'(CHR_RAM_BANKS_1K);

    always_comb
    begin
        unique case (a[14:13])
            2'b00:   prg_bank = swap ? second_last : bank_val[5:0];
            2'b01:   prg_bank = bank_val[5:0];
            2'b10:   prg_bank = swap ? bank_val[5:0] : second_last;
            default: prg_bank = last;
        endcase
    end

    assign wr_idx = sel_byte[2:0];

    always_comb
    begin
        result.target         = mmc3_pkg::TARGET_NONE;
        result.mapped_address = '0;
        result.write_enable   = 1'b0;
        result.dropped        = 1'b0;
        update.sel_we         = 1'b0;
        update.bank_we        = 1'b0;
        update.bank_idx       = wr_idx;
        update.mirror_we      = 1'b0;
        update.data           = item.write_data;

        if (is_ppu)
        begin
            if (a >= mmc3_pkg::ADDR_PATTERN_END)
            begin
                result.dropped = is_write;
            end
            else
            begin
                result.target         = mmc3_pkg::TARGET_CHR;
                result.mapped_address = {1'b0, chr_addr};
                if (is_write)
                begin
                    if (cfg.chr_is_rom || chr_out_of_range)
                        result.dropped = 1'b1;
                    else
                        result.write_enable = 1'b1;
                end
            end
        end
        else if (a < mmc3_pkg::ADDR_UNMAPPED)
        begin
            result.mapped_address = {3'd0, a};
        end
        else if (a < mmc3_pkg::ADDR_PRG_RAM)
        begin
            result.dropped = is_write;
        end
        else if (a < mmc3_pkg::ADDR_PRG_ROM)
        begin
            if (cfg.prg_ram_present)
            begin
                result.target         = mmc3_pkg::TARGET_PRG_RAM;
                result.mapped_address = {6'd0, a[12:0]};
                result.write_enable   = is_write;
            end
            else
            begin
                result.dropped = is_write;
            end
        end
        else if (!is_write)
        begin
            result.target         = mmc3_pkg::TARGET_PRG_ROM;
            result.mapped_address = {prg_bank, a[12:0]};
        end
        else if (a < mmc3_pkg::ADDR_MIRROR)
        begin
            if (a[0])
            begin
                update.bank_we = 1'b1;
                if (wr_idx < 3'd2)
                    update.data = item.write_data & mmc3_pkg::CHR_2K_MASK;
                else if (wr_idx > 3'd5)
                    update.data = item.write_data & mmc3_pkg::PRG_MASK;
            end
            else
            begin
                update.sel_we = 1'b1;
            end
        end
        else if (a[14:13] == 2'b01)
        begin
            update.mirror_we = ~a[0];
        end

        // Mirroring as it stands after this access.
        result.mirror_horizontal = update.mirror_we ? item.write_data[0] : mirroring;
    end

endmodule

@@ design/mmc3_bank_mapper.sv @@
// ----------------------------------------------------------------------------
// mmc3_bank_mapper
// MMC3 bank switching: translates CPU and PPU bus accesses into PRG RAM,
// PRG ROM and CHR addresses and tracks the bank and mirroring registers.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid, in_stall, in_data) carries one bus access per
// beat: command, bus address and write data. The output channel (out_valid,
// out_stall, out_data) returns exactly one result beat per access, in order:
// target memory, mapped address, write enable, drop flag and the mirroring
// bit as it stands after the access.
// An accepted beat is registered in the input register, translated by the
// combinational logic and registered again in the result register. One beat
// is accepted per cycle, sustained, while the receiver does not stall: the
// single pass from the input register through the translation logic to the
// result register is the whole job. Register writes take effect for the very
// next beat. When the receiver stalls, the result register holds; the input
// register still takes one more beat and then in_stall rises until the
// result moves. Reset clears both pipeline stages, the select byte, the
// eight bank registers and mirroring, and loads the configuration defaults
// (32 PRG banks, PRG RAM present, CHR ROM). The APB port is to be written
// only while idle; the user must see to that, as the block has no guard.
// ----------------------------------------------------------------------------
module mmc3_bank_mapper #(
    parameter int unsigned CHR_RAM_BANKS_1K = 8
) (
    input  logic                clk,
    input  logic                rst_n,

    input  logic                in_valid,
    output logic                in_stall,
    input  mmc3_pkg::in_item_t  in_data,

    output logic                out_valid,
    input  logic                out_stall,
    output mmc3_pkg::out_item_t out_data,

    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    mmc3_pkg::cfg_t        cfg_reg;
    mmc3_pkg::in_item_t    in_item_reg;
    mmc3_pkg::out_item_t   out_item_reg;
    mmc3_pkg::out_item_t   result;
    mmc3_pkg::map_update_t update;

    logic                  in_valid_reg;
    logic                  out_valid_reg;
    logic                  advance;
    logic                  fire;
    logic                  cfg_write;
    logic [7:0]            sel_byte_reg;
    logic [7:0][7:0]       bank_regs_reg;
    logic                  mirroring_reg;

    // The result stage moves whenever it is empty or being taken.
    assign advance  = !out_valid_reg || !out_stall;
    assign fire     = advance && in_valid_reg;
    assign in_stall = in_valid_reg && !advance;

    assign out_valid = out_valid_reg;
    assign out_data  = out_item_reg;

    // Configuration port. Writes complete in the access phase; pready is
    // tied high so no wait states are inserted.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_comb
    begin
        unique case (paddr[3:2])
            mmc3_pkg::REG_PRG_BANK_COUNT:  prdata = {25'd0, cfg_reg.prg_bank_count};
            mmc3_pkg::REG_PRG_RAM_PRESENT: prdata = {31'd0, cfg_reg.prg_ram_present};
            mmc3_pkg::REG_CHR_IS_ROM:      prdata = {31'd0, cfg_reg.chr_is_rom};
            default:                       prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.prg_bank_count  <= mmc3_pkg::PRG_BANK_COUNT_RESET;
            cfg_reg.prg_ram_present <= 1'b1;
            cfg_reg.chr_is_rom      <= 1'b1;
        end
        else if (cfg_write)
        begin
            unique case (paddr[3:2])
                mmc3_pkg::REG_PRG_BANK_COUNT:  cfg_reg.prg_bank_count  <= pwdata[6:0];
                mmc3_pkg::REG_PRG_RAM_PRESENT: cfg_reg.prg_ram_present <= pwdata[0];
                mmc3_pkg::REG_CHR_IS_ROM:      cfg_reg.chr_is_rom      <= pwdata[0];
                default:                       ;
            endcase
        end
    end

    // Input register: holds the access being translated this cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (!in_stall)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
            in_item_reg <= in_data;
    end

    mmc3_xlate #(
        .CHR_RAM_BANKS_1K (CHR_RAM_BANKS_1K)
    ) u_xlate (
        .item      (in_item_reg),
        .cfg       (cfg_reg),
        .sel_byte  (sel_byte_reg),
        .banks     (bank_regs_reg),
        .mirroring (mirroring_reg),
        .result    (result),
        .update    (update)
    );

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= in_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (fire)
            out_item_reg <= result;
    end

    // Mapper registers change at the edge that registers the access's
    // result, so the next access already sees the new banks.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_byte_reg  <= '0;
            bank_regs_reg <= '0;
            mirroring_reg <= 1'b0;
        end
        else if (fire)
        begin
            if (update.sel_we)
                sel_byte_reg <= update.data;
            if (update.bank_we)
                bank_regs_reg[update.bank_idx] <= update.data;
            if (update.mirror_we)
                mirroring_reg <= update.data[0];
        end
    end

endmodule

@@ design/mmc3_checker.sv @@
// ----------------------------------------------------------------------------
// mmc3_port_checks
// Port-level checks of the MMC3 bank mapper, bound to the top level.
// ----------------------------------------------------------------------------
module mmc3_port_checks (
    input logic                clk,
    input logic                rst_n,
    input logic                out_valid,
    input logic                out_stall,
    input mmc3_pkg::out_item_t out_data
);

    // A stalled result stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result withdrawn while stalled");

    // A stalled result does not change.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(out_data))
        else $error("result changed while stalled");

    // A write is either performed or dropped, never both.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(out_data.write_enable && out_data.dropped))
        else $error("write both enabled and dropped");

    // Only PRG RAM and CHR can be written.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.write_enable |->
            (out_data.target == mmc3_pkg::TARGET_PRG_RAM) ||
            (out_data.target == mmc3_pkg::TARGET_CHR))
        else $error("write enabled to a read-only or absent target");

    // A drop concerns either no target or CHR.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.dropped |->
            (out_data.target == mmc3_pkg::TARGET_NONE) ||
            (out_data.target == mmc3_pkg::TARGET_CHR))
        else $error("dropped write reported against PRG memory");

endmodule

bind mmc3_bank_mapper mmc3_port_checks u_mmc3_port_checks (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);
